### rtl/core/qosc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// qosc_pkg
// Shared widths, constants, sequencer control bundle and saturation helper
// for the quadrature oscillator block.
// ============================================================================
package qosc_pkg;

    // Sample / coefficient format: signed Q2.16
    localparam int SMP_W   = 18;
    localparam int OPA_W   = 19;              // multiplier A operand (holds scale)
    localparam int PROD_W  = OPA_W + SMP_W;   // full product
    localparam int ASR_W   = PROD_W - 16;     // product after >>> 16
    localparam int SUM_W   = ASR_W + 1;       // sum of two shifted products

    localparam logic signed [SMP_W-1:0] ONE_Q16    = 18'sh10000;
    localparam logic signed [SMP_W-1:0] SAMPLE_MAX = 18'sh1FFFF;
    localparam logic signed [SMP_W-1:0] SAMPLE_MIN = 18'sh20000;
    localparam logic signed [SUM_W-1:0] SAT_HI     = 22'sd131071;
    localparam logic signed [SUM_W-1:0] SAT_LO     = -22'sd131072;
    localparam logic signed [SUM_W-1:0] ONE_HALF_Q16 = 22'sd98304;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN = 1'b1;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        OPA_COS,
        OPA_SIN,
        OPA_RE,
        OPA_IM,
        OPA_SCALE
    } opa_t;

    typedef enum logic [0:0] {
        OPB_RE,
        OPB_IM
    } opb_t;

    // Per-cycle strobes from the sequencer to the datapath
    typedef struct packed {
        logic mul_en;      // latch a new product
        opa_t opa;
        opb_t opb;
        logic acc_load;    // acc <= product >>> 16
        logic tmp_rot;     // tmp <= sat(acc - product >>> 16)
        logic tmp_nrm;     // tmp <= sat(product >>> 16)
        logic scale_ld;    // scale <= 1.5 - power / 2
        logic commit_rot;  // phasor <= rotated sample
        logic commit_nrm;  // phasor <= renormalized sample
        logic restart_ld;  // phasor <= (1, 0)
    } qosc_ctl_t;

    function automatic logic signed [SMP_W-1:0] sat18(input logic signed [SUM_W-1:0] x);
        logic signed [SMP_W-1:0] r;
        if (x > SAT_HI)
            r = SAMPLE_MAX;
        else if (x < SAT_LO)
            r = SAMPLE_MIN;
        else
            r = x[SMP_W-1:0];
        return r;
    endfunction

endpackage

### rtl/core/qosc_if.sv
`timescale 1ns / 1ps
// ============================================================================
// qosc_if
// Valid/ready channels of the oscillator: block requests in, samples out.
// ============================================================================
interface qosc_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface qosc_smp_if
    import qosc_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  out_real;
    logic signed [SMP_W-1:0]  out_imag;
    logic                     last_of_block;

    modport source (output valid, output out_real, output out_imag,
                    output last_of_block, input ready);
    modport sink   (input valid, input out_real, input out_imag,
                    input last_of_block, output ready);
endinterface

### rtl/core/qosc_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// qosc_dp
// Shared multiply / shift / accumulate unit with phasor, scratch and scale
// registers. One product per cycle while mul_en is set, accumulated in the next cycle.
// ============================================================================
module qosc_dp
    import qosc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  qosc_ctl_t                ctl,
    input  logic signed [SMP_W-1:0]  cos_coef,
    input  logic signed [SMP_W-1:0]  sin_coef,
    output logic signed [SMP_W-1:0]  smp_re,
    output logic signed [SMP_W-1:0]  smp_im
);

    logic signed [SMP_W-1:0]  re_reg, re_next;
    logic signed [SMP_W-1:0]  im_reg, im_next;
    logic signed [SMP_W-1:0]  tmp_reg;
    logic signed [OPA_W-1:0]  scale_reg;
    logic signed [ASR_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [OPA_W-1:0]  mul_a;
    logic signed [SMP_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [SUM_W-1:0]  p_ext;
    logic signed [SUM_W-1:0]  acc_ext;
    logic signed [SUM_W-1:0]  sum_add;
    logic signed [SUM_W-1:0]  sum_sub;
    logic signed [SUM_W-1:0]  scale_full;
    logic signed [SMP_W-1:0]  im_rot;
    logic signed [SMP_W-1:0]  im_nrm;

    // operand select
    always_comb
    begin
        case (ctl.opa)
            OPA_COS:   mul_a = {cos_coef[SMP_W-1], cos_coef};
            OPA_SIN:   mul_a = {sin_coef[SMP_W-1], sin_coef};
            OPA_RE:    mul_a = {re_reg[SMP_W-1], re_reg};
            OPA_IM:    mul_a = {im_reg[SMP_W-1], im_reg};
            OPA_SCALE: mul_a = scale_reg;
            default:   mul_a = '0;
        endcase
        case (ctl.opb)
            OPB_RE:  mul_b = re_reg;
            OPB_IM:  mul_b = im_reg;
            default: mul_b = '0;
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // product >>> 16 and the adder
    assign p_ext      = {prod_reg[PROD_W-1], prod_reg[PROD_W-1:16]};
    assign acc_ext    = {acc_reg[ASR_W-1], acc_reg};
    assign sum_add    = acc_ext + p_ext;
    assign sum_sub    = acc_ext - p_ext;
    assign scale_full = ONE_HALF_Q16 - (sum_add >>> 1);
    assign im_rot     = sat18(sum_add);
    assign im_nrm     = sat18(p_ext);

    // outgoing sample
    assign smp_re = tmp_reg;
    assign smp_im = ctl.commit_nrm ? im_nrm : im_rot;

    // scratch registers, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg <= prod_full;
        if (ctl.acc_load)
            acc_reg <= prod_reg[PROD_W-1:16];
        if (ctl.tmp_rot)
            tmp_reg <= sat18(sum_sub);
        else if (ctl.tmp_nrm)
            tmp_reg <= im_nrm;
        if (ctl.scale_ld)
            scale_reg <= scale_full[OPA_W-1:0];
    end

    // phasor update
    always_comb
    begin
        re_next = re_reg;
        im_next = im_reg;
        if (ctl.restart_ld)
        begin
            re_next = ONE_Q16;
            im_next = '0;
        end
        else if (ctl.commit_rot || ctl.commit_nrm)
        begin
            re_next = tmp_reg;
            im_next = smp_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_reg <= ONE_Q16;
            im_reg <= '0;
        end
        else
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

endmodule

### rtl/core/qosc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// qosc_ctrl
// Sequencer: steps the shared unit through rotation, power, renormalization
// and sample emission, and counts samples within the block.
// ============================================================================
module qosc_ctrl
    import qosc_pkg::*;
#(
    parameter int SAMPLES_PER_BLOCK = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_restart,
    output logic       req_ready,
    input  logic       out_free,
    output qosc_ctl_t  ctl,
    output logic       emit,
    output logic       last
);

    localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BLOCK - 1);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_ROT0 = 13'b0000000000010,
        S_ROT1 = 13'b0000000000100,
        S_ROT2 = 13'b0000000001000,
        S_ROT3 = 13'b0000000010000,
        S_ROT4 = 13'b0000000100000,
        S_PWR0 = 13'b0000001000000,
        S_PWR1 = 13'b0000010000000,
        S_PWR2 = 13'b0000100000000,
        S_NRM0 = 13'b0001000000000,
        S_NRM1 = 13'b0010000000000,
        S_NRM2 = 13'b0100000000000,
        S_SPARE = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             first_reg, first_next;

    assign last = (cnt_reg == CNT_LAST);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        req_ready  = 1'b0;
        emit       = 1'b0;
        ctl        = '0;
        ctl.opa    = OPA_COS;
        ctl.opb    = OPB_RE;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.restart_ld = req_restart;
                    first_next     = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_ROT0;
                end
            end
            // rotation: re' = c*re - s*im, im' = s*re + c*im
            S_ROT0:
            begin
                ctl.mul_en = 1'b1;
                state_next = S_ROT1;
            end
            S_ROT1:
            begin
                ctl.mul_en   = 1'b1;
                ctl.opa      = OPA_SIN;
                ctl.opb      = OPB_IM;
                ctl.acc_load = 1'b1;
                state_next   = S_ROT2;
            end
            S_ROT2:
            begin
                ctl.mul_en  = 1'b1;
                ctl.opa     = OPA_SIN;
                ctl.tmp_rot = 1'b1;
                state_next  = S_ROT3;
            end
            S_ROT3:
            begin
                ctl.mul_en   = 1'b1;
                ctl.opb      = OPB_IM;
                ctl.acc_load = 1'b1;
                state_next   = S_ROT4;
            end
            S_ROT4:
            begin
                if (first_reg)
                begin
                    ctl.commit_rot = 1'b1;
                    state_next     = S_PWR0;
                end
                else if (out_free)
                begin
                    ctl.commit_rot = 1'b1;
                    emit           = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = last ? S_IDLE : S_ROT0;
                end
            end
            // power = re^2 + im^2, scale = 1.5 - power/2
            S_PWR0:
            begin
                ctl.mul_en = 1'b1;
                ctl.opa    = OPA_RE;
                state_next = S_PWR1;
            end
            S_PWR1:
            begin
                ctl.mul_en   = 1'b1;
                ctl.opa      = OPA_IM;
                ctl.opb      = OPB_IM;
                ctl.acc_load = 1'b1;
                state_next   = S_PWR2;
            end
            S_PWR2:
            begin
                ctl.scale_ld = 1'b1;
                state_next   = S_NRM0;
            end
            // first sample scaled by the renormalization factor
            S_NRM0:
            begin
                ctl.mul_en = 1'b1;
                ctl.opa    = OPA_SCALE;
                state_next = S_NRM1;
            end
            S_NRM1:
            begin
                ctl.mul_en  = 1'b1;
                ctl.opa     = OPA_SCALE;
                ctl.opb     = OPB_IM;
                ctl.tmp_nrm = 1'b1;
                state_next  = S_NRM2;
            end
            S_NRM2:
            begin
                if (out_free)
                begin
                    ctl.commit_nrm = 1'b1;
                    emit           = 1'b1;
                    first_next     = 1'b0;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = last ? S_IDLE : S_ROT0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

endmodule

### rtl/core/quadrature_oscillator_block.sv
`timescale 1ns / 1ps
// The first sample of a block is rotated and renormalized before emission;
// each later sample takes four products through the single shared
// multiplier plus a commit step. Output stalls hold the sequencer, and a
// new request is accepted only once the whole block has been emitted.
// Reset: phasor (1,0), cos_coef = 1.0, sin_coef = 0, sequencer idle.
// ============================================================================
// quadrature_oscillator_block
// Coupled-form quadrature oscillator producing blocks of Q2.16 complex
// samples with first-order renormalization of the first sample of a block.
// ============================================================================
module quadrature_oscillator_block
    import qosc_pkg::*;
#(
    parameter int SAMPLES_PER_BLOCK = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [SMP_W-1:0]      cfg_wdata,
    qosc_req_if.sink              req,
    qosc_smp_if.source            samples
);

    logic signed [SMP_W-1:0] cos_coef_reg;
    logic signed [SMP_W-1:0] sin_coef_reg;
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] out_re_reg;
    logic signed [SMP_W-1:0] out_im_reg;
    logic                    out_last_reg;

    qosc_ctl_t               ctl;
    logic                    emit;
    logic                    last;
    logic                    out_free;
    logic signed [SMP_W-1:0] smp_re;
    logic signed [SMP_W-1:0] smp_im;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_coef_reg <= ONE_Q16;
            sin_coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_COS: cos_coef_reg <= cfg_wdata;
                CFG_SIN: sin_coef_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || samples.ready;

    qosc_ctrl #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_restart (req.restart),
        .req_ready   (req.ready),
        .out_free    (out_free),
        .ctl         (ctl),
        .emit        (emit),
        .last        (last)
    );

    qosc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cos_coef (cos_coef_reg),
        .sin_coef (sin_coef_reg),
        .smp_re   (smp_re),
        .smp_im   (smp_im)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (samples.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_re_reg   <= smp_re;
            out_im_reg   <= smp_im;
            out_last_reg <= last;
        end
    end

    assign samples.valid         = out_valid_reg;
    assign samples.out_real      = out_re_reg;
    assign samples.out_imag      = out_im_reg;
    assign samples.last_of_block = out_last_reg;

endmodule
